// ----- src/ccd_pkg.sv -----
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared types and constants for the crank/cam decoder: divider widths,
// reciprocal constant, pulse counter limits, tick rate reset value and the
// inter-module structs.
// ----------------------------------------------------------------------------
package ccd_pkg;

   // Divider geometry: the rpm numerator is ticks_per_second * 60 (< 2^38),
   // the divisor is period * TEETH_PER_REV (< 2^38 for up to 64 teeth).
   localparam int NUM_W     = 38;
   localparam int DIV_W     = 38;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   // Field widths of the result.
   localparam int PHASE_OUT_W = 6;
   localparam int TPD_W       = 29;
   localparam int RPM_W       = 16;

   // x / 15 == (x * RECIP_15) >> RECIP_SHIFT for every 32-bit x.
   localparam logic [31:0] RECIP_15    = 32'h8888_8889;
   localparam int          RECIP_SHIFT = 35;

   // Long-pulse counter: the fifth long pulse syncs, the count stops at six.
   localparam logic [2:0] LPC_MAX     = 3'd6;
   localparam logic [2:0] SYNC_PULSES = 3'd5;
   localparam int         SYNC_PHASE  = 5;

   // Tick rate after reset.
   localparam logic [31:0] TPS_RESET = 32'd1000000;

   // Event source codes.
   localparam logic OP_CRANK = 1'b0;
   localparam logic OP_CAM   = 1'b1;

   // Request to the shared divider.
   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   // Status of the shared divider.
   typedef struct packed {
      logic             busy;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

   // Decoder state seen by the result path.
   typedef struct packed {
      logic [PHASE_OUT_W-1:0] phase;
      logic [31:0]            period;
      logic                   synced;
      logic                   cam_known;
   } track_status_type;

endpackage

// ----- src/ccd_div.sv -----
// ----------------------------------------------------------------------------
// ccd_div
// Shared restoring divider: one quotient bit per cycle. The quotient stays
// valid until the next start.
// ----------------------------------------------------------------------------
module ccd_div
   import ccd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]     work_ff, work_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_W:0]       rem_sh;
   logic [DIV_W:0]       rem_sub;
   logic                 q_bit;

   // One shift-and-subtract step.
   always_comb begin
      rem_sh  = {rem_ff, work_ff[NUM_W-1]};
      q_bit   = (rem_sh >= {1'b0, dsr_ff});
      rem_sub = q_bit ? (rem_sh - {1'b0, dsr_ff}) : rem_sh;
   end

   // Sequencing of the iterations.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         work_in = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[NUM_W-2:0], q_bit};
         rem_in  = rem_sub[DIV_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.quotient = work_ff;

endmodule

// ----- src/ccd_track.sv -----
// ----------------------------------------------------------------------------
// ccd_track
// Tooth phase tracker: applies one crank or cam edge per transfer to the
// phase, period, timestamps, cam and sync flags and the long-pulse count.
// ----------------------------------------------------------------------------
module ccd_track
   import ccd_pkg::*;
#(
   parameter int TEETH_PER_REV = 24
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             apply,
   input  logic             operation,
   input  logic             edge_req,
   input  logic [31:0]      event_time,
   output track_status_type status
);

   localparam int PHASE_W = $clog2(2 * TEETH_PER_REV);

   localparam logic [PHASE_W-1:0] PH_REV   = PHASE_W'(TEETH_PER_REV);
   localparam logic [PHASE_W:0]   LIM_ONE  = (PHASE_W + 1)'(TEETH_PER_REV - 1);
   localparam logic [PHASE_W:0]   LIM_TWO  = (PHASE_W + 1)'(2 * TEETH_PER_REV - 1);
   localparam logic [PHASE_W-1:0] PH_SYNC  = PHASE_W'(SYNC_PHASE);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [31:0]        period_ff, period_in;
   logic [31:0]        crank_t_ff, crank_t_in;
   logic [31:0]        cam_t_ff, cam_t_in;
   logic               seen_ff, seen_in;
   logic               known_ff, known_in;
   logic               sync_ff, sync_in;
   logic [2:0]         lpc_ff, lpc_in;

   logic [31:0]    delta_crank;
   logic [31:0]    delta_cam;
   logic           advance;
   logic [PHASE_W:0] phase_inc;
   logic [PHASE_W:0] limit;
   logic [34:0]    lhs_pulse;
   logic [34:0]    rhs_pulse;
   logic           short_pulse;
   logic [2:0]     lpc_inc;

   // Time differences are modulo 2^32.
   always_comb begin
      delta_crank = event_time - crank_t_ff;
      delta_cam   = event_time - cam_t_ff;
      // A crank edge right after a cam edge does not move phase 0 or one revolution.
      advance     = ((phase_ff != '0) && (phase_ff != PH_REV)) ||
                    (delta_cam > {2'b00, delta_crank[31:2]});
      phase_inc   = {1'b0, phase_ff} + 1'b1;
      limit       = (!known_ff && !seen_ff) ? LIM_ONE : LIM_TWO;
      // 10*interval > 6*period is the same test as 5*interval > 3*period.
      lhs_pulse   = {1'b0, delta_crank, 2'b00} + {3'b000, delta_crank};
      rhs_pulse   = {2'b00, period_ff, 1'b0} + {3'b000, period_ff};
      short_pulse = (lhs_pulse > rhs_pulse);
      lpc_inc     = lpc_ff + 1'b1;
   end

   // Event decode.
   always_comb begin
      phase_in   = phase_ff;
      period_in  = period_ff;
      crank_t_in = crank_t_ff;
      cam_t_in   = cam_t_ff;
      seen_in    = seen_ff;
      known_in   = known_ff;
      sync_in    = sync_ff;
      lpc_in     = lpc_ff;
      if (apply) begin
         if (operation == OP_CAM) begin
            cam_t_in = event_time;
            seen_in  = 1'b1;
            sync_in  = 1'b1;
            known_in = 1'b1;
            phase_in = edge_req ? PH_REV : '0;
         end else if (!edge_req) begin
            // Falling crank edge: new period and phase step.
            period_in  = delta_crank;
            crank_t_in = event_time;
            if (advance) begin
               if (phase_inc > limit) begin
                  phase_in = '0;
                  known_in = seen_ff;
                  seen_in  = 1'b0;
               end else begin
                  phase_in = phase_inc[PHASE_W-1:0];
               end
            end
         end else if (!known_ff) begin
            // Rising crank edge: pulse width classification.
            if (short_pulse) begin
               lpc_in = '0;
            end else if (lpc_ff < LPC_MAX) begin
               lpc_in = lpc_inc;
               if (lpc_inc == SYNC_PULSES) begin
                  phase_in = PH_SYNC;
                  sync_in  = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         period_ff  <= '0;
         crank_t_ff <= '0;
         cam_t_ff   <= '0;
         seen_ff    <= 1'b0;
         known_ff   <= 1'b1;
         sync_ff    <= 1'b0;
         lpc_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         period_ff  <= period_in;
         crank_t_ff <= crank_t_in;
         cam_t_ff   <= cam_t_in;
         seen_ff    <= seen_in;
         known_ff   <= known_in;
         sync_ff    <= sync_in;
         lpc_ff     <= lpc_in;
      end
   end

   assign status.phase     = PHASE_OUT_W'(phase_ff);
   assign status.period    = period_ff;
   assign status.synced    = sync_ff;
   assign status.cam_known = known_ff;

endmodule

// ----- src/crank_cam_24x_decoder_unit.sv -----
// An accepted edge updates the tooth state at its accepting clock edge, and
// its result is then offered: the S_START state starts the rpm division, the
// shared bit-serial divider runs (one quotient bit per cycle over a 38-bit
// numerator) and the S_DIV state loads the output register. req_tready is low
// from the accepting edge until the result is loaded, so no edge is taken
// before the result of the one before it is loaded. The next edge is taken
// even while a loaded result still waits; its finished division then holds
// until the output register is free. Engine speed is ticks_per_second*60
// divided by period*TEETH_PER_REV in a single division. ticks_per_second
// writes apply from the next edge; req_tready is also low during a write.
// ----------------------------------------------------------------------------
// crank_cam_24x_decoder_unit
// Crank/cam edge decoder: tooth phase over two revolutions, tooth period,
// sync and cam flags, ticks per degree and engine speed.
// ----------------------------------------------------------------------------
module crank_cam_24x_decoder_unit
   import ccd_pkg::*;
#(
   parameter int TEETH_PER_REV = 24
)
(
   input  logic         clock,
   input  logic         reset,
   // Edge channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // event_time[31:0]
   input  logic [1:0]   req_tuser,   // operation[0], edge_req[1]
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,   // tooth_phase[5:0], tooth_period[37:6],
                                     // is_synced[38], cam_known[39],
                                     // ticks_per_degree[68:40],
                                     // engine_rpm[84:69], zero fill [87:85]
   // Tick rate register.
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata
);

   localparam logic [DIV_W-1:0] TEETH_MUL  = DIV_W'(TEETH_PER_REV);
   localparam logic [NUM_W-1:0] RPM_LIMIT  = NUM_W'(65535);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_START = 3'b010,
      S_DIV   = 3'b100
   } seq_state_type;

   seq_state_type    state_ff, state_in;
   logic [31:0]      tps_ff, tps_in;
   logic [63:0]      prod_ff, prod_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [87:0]      rsp_data_ff, rsp_data_in;

   div_req_type      div_req;
   div_rsp_type      div_rsp;
   track_status_type status;

   logic             req_xfer;
   logic             rsp_free;
   logic [NUM_W-1:0] tps_x60;
   logic [DIV_W-1:0] period_x_teeth;
   logic [RPM_W-1:0] rpm;
   logic [TPD_W-1:0] tpd;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !csr_we;

   // ticks_per_second * 60 as 64x - 4x.
   assign tps_x60 = {tps_ff, 6'b000000} - {4'b0000, tps_ff, 2'b00};

   // Tooth period scaled to one revolution, a multiply by a constant.
   assign period_x_teeth = DIV_W'(status.period) * TEETH_MUL;

   ccd_track #(
      .TEETH_PER_REV(TEETH_PER_REV)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .apply      (req_xfer),
      .operation  (req_tuser[0]),
      .edge_req   (req_tuser[1]),
      .event_time (req_tdata),
      .status     (status)
   );

   ccd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Result fields.
   always_comb begin
      tpd = prod_ff[RECIP_SHIFT +: TPD_W];
      if (status.period == '0) begin
         rpm = '0;
      end else if (div_rsp.quotient > RPM_LIMIT) begin
         rpm = '1;
      end else begin
         rpm = div_rsp.quotient[RPM_W-1:0];
      end
   end

   // Sequencer and tick rate register.
   always_comb begin
      state_in         = state_ff;
      tps_in           = tps_ff;
      prod_in          = prod_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;
      div_req.start    = 1'b0;
      div_req.dividend = tps_x60;
      div_req.divisor  = period_x_teeth;
      if (csr_we) begin
         tps_in = csr_wdata;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_START;
            end
         end
         S_START: begin
            div_req.start = 1'b1;
            prod_in       = status.period * RECIP_15;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!div_rsp.busy && rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'd0, rpm, tpd, status.cam_known, status.synced,
                               status.period, status.phase};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tps_ff       <= TPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tps_ff       <= tps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An accepted edge always moves on to the division start.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_START))
      else $error("accepted edge did not start the rpm division");

   // The divider is never restarted by an edge while it is still iterating.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START) |-> !div_rsp.busy)
      else $error("rpm division started while divider busy");

   // A zero period always reports zero speed.
   a_zero_rpm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[37:6] == '0)) |-> (rsp_data_ff[84:69] == '0))
      else $error("nonzero rpm with zero period");

   // Ticks per degree never exceeds a fifteenth of the period.
   a_tpd_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((33'(rsp_data_ff[68:40]) * 33'd15) <= 33'(rsp_data_ff[37:6])))
      else $error("ticks per degree out of range");

   // A result is loaded only when the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_data_ff))
      else $error("pending result overwritten");

endmodule
